@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_CLK_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif
`endif

@@ hw/rtl/bhn_pkg.sv @@
// package for the heightfield normal block: constants and types
// no dependencies
`default_nettype none
package bhn_pkg;
   localparam int MAX_ROW_DEF = 256;
   localparam int HEIGHT_W = 24;
   localparam int NORM_W = 16;
   localparam logic [7:0] CELLS_RESET = 8'd64;
   localparam logic [23:0] STEP_RESET = 24'd1024;
   localparam logic CSR_CELLS = 1'b0;
   localparam logic CSR_STEP = 1'b1;
   typedef logic signed [HEIGHT_W-1:0] height_type;
endpackage
`default_nettype wire

@@ hw/rtl/bordered_heightfield_normals_top.sv @@
// top level of the heightfield normal block: window, row stores and sequencer
// depends on bhn_pkg and assert_macros.svh
//
// After reset the row stores are cleared one column per cycle, so the input
// is stalled until all MAX_ROW columns (256 by default) are cleared. A height
// word that yields a normal keeps the block busy while it works through its
// steps in order: it shifts the window and forms the sums, takes the squares
// on one 32x32 multiplier, runs the square root, runs the three 15-step
// divides, and moves the normal into the output register; the next word is
// taken only after that. The square root and the divides all run on one
// shared 64-bit add/compare unit. A word that yields no normal returns the
// block to idle once the window is shifted. While a normal waits in the
// output register the block takes and works on the next word, and then holds
// until the output is free. Configuration writes are taken only while the
// block is idle, and a pending write stalls the input.
`default_nettype none
`include "assert_macros.svh"
module bordered_heightfield_normals_top
   import bhn_pkg::*;
#(
   parameter int MAX_ROW = MAX_ROW_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [23:0] req_height,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_normal_x,
   output logic signed [15:0]      rsp_normal_y,
   output logic signed [15:0]      rsp_normal_z,
   output logic                    rsp_last,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [0:0]         csr_index,
   input  wire logic [23:0]        csr_data
);
   localparam int CW = $clog2(MAX_ROW);
   localparam logic [3:0] S_IDLE = 4'd0, S_CLEAR = 4'd1, S_READ = 4'd2, S_CALC = 4'd3,
      S_SQ = 4'd4, S_SQRT = 4'd5, S_DINIT = 4'd6, S_DIV = 4'd7, S_OUT = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [7:0] cells_ff;
   logic [23:0] step_ff;
   logic [8:0] col_ff, row_ff;
   logic [CW-1:0] cidx_ff, clr_ff;
   height_type older_mem [MAX_ROW];
   height_type newer_mem [MAX_ROW];
   height_type rd_o_ff, rd_n_ff, h_ff;
   height_type w_ff [9];
   logic emit_ff, lastf_ff;
   logic signed [27:0] ax_ff, az_ff;
   logic [26:0] ay_ff;
   logic [63:0] s_ff, res_ff, bit_ff;
   logic [1:0] sq_ff, comp_ff;
   logic [14:0] quo_ff;
   logic [3:0] dcnt_ff;
   logic signed [15:0] cx_ff, cy_ff, cz_ff;
   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic lo_ff, rv_ff;

   logic [8:0] r_eff, size;
   logic accept, out_load;
   logic [CW-1:0] cidx;
   logic [31:0] mop;
   logic [63:0] sqr, opb, dif;
   logic ge;
   logic [27:0] mag;
   logic neg;
   logic [14:0] qn;
   logic signed [15:0] cval;

   always_comb begin
      r_eff = {1'b0, cells_ff};
      if (r_eff < 9'd1) r_eff = 9'd1;
      if (r_eff + 9'd3 > 9'(MAX_ROW)) r_eff = 9'(MAX_ROW - 3);
      size = r_eff + 9'd3;
   end

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign cidx = col_ff[CW-1:0];
   assign out_load = (state_ff == S_OUT) && (!rv_ff || !rsp_stall);

   always_comb begin
      case (sq_ff)
         2'd0: mop = 32'(ax_ff < 0 ? -ax_ff : ax_ff);
         2'd1: mop = 32'(ay_ff);
         default: mop = 32'(az_ff < 0 ? -az_ff : az_ff);
      endcase
      sqr = mop * mop;
   end

   // shared add/compare unit for the square root and the divides
   always_comb begin
      case (comp_ff)
         2'd0: begin
            mag = 28'(ax_ff < 0 ? -ax_ff : ax_ff);
            neg = ax_ff[27];
         end
         2'd1: begin
            mag = {1'b0, ay_ff};
            neg = 1'b0;
         end
         default: begin
            mag = 28'(az_ff < 0 ? -az_ff : az_ff);
            neg = az_ff[27];
         end
      endcase
      opb = (state_ff == S_SQRT) ? res_ff + bit_ff : bit_ff;
      ge = s_ff >= opb;
      dif = s_ff - opb;
      qn = {quo_ff[13:0], ge};
      cval = (res_ff == '0) ? 16'sd0 : $signed({1'b0, qn});
      if (neg) cval = -cval;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_o_ff <= older_mem[cidx];
         rd_n_ff <= newer_mem[cidx];
         h_ff <= req_height;
         cidx_ff <= cidx;
      end
      if (state_ff == S_CLEAR) begin
         older_mem[clr_ff] <= '0;
         newer_mem[clr_ff] <= '0;
      end else if (state_ff == S_READ) begin
         older_mem[cidx_ff] <= rd_n_ff;
         newer_mem[cidx_ff] <= h_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_READ;
         S_CLEAR: if (clr_ff == CW'(MAX_ROW - 1)) state_in = S_IDLE;
         S_READ: state_in = emit_ff ? S_CALC : S_IDLE;
         S_CALC: state_in = S_SQ;
         S_SQ: if (sq_ff == 2'd2) state_in = S_SQRT;
         S_SQRT: if (bit_ff[0]) state_in = S_DINIT;
         S_DINIT: state_in = S_DIV;
         S_DIV: if (dcnt_ff == 4'd0) state_in = (comp_ff == 2'd2) ? S_OUT : S_DINIT;
         S_OUT: if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         cells_ff <= CELLS_RESET;
         step_ff <= STEP_RESET;
         col_ff <= '0;
         row_ff <= '0;
         emit_ff <= 1'b0;
         lastf_ff <= 1'b0;
         rv_ff <= 1'b0;
         lo_ff <= 1'b0;
         nx_ff <= '0;
         ny_ff <= '0;
         nz_ff <= '0;
         for (int k = 0; k < 9; k++) w_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + CW'(1);
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CELLS) cells_ff <= csr_data[7:0];
            else step_ff <= csr_data;
         end
         if (accept) begin
            emit_ff <= row_ff >= 9'd2 && col_ff >= 9'd2 && row_ff <= r_eff + 9'd2
               && col_ff <= r_eff + 9'd2;
            lastf_ff <= row_ff == r_eff + 9'd2 && col_ff == r_eff + 9'd2;
            if (col_ff + 9'd1 >= size) begin
               col_ff <= '0;
               row_ff <= (row_ff + 9'd1 >= size) ? 9'd0 : row_ff + 9'd1;
            end else col_ff <= col_ff + 9'd1;
         end
         if (state_ff == S_READ) begin
            for (int k = 0; k < 3; k++) begin
               w_ff[k*3] <= w_ff[k*3+1];
               w_ff[k*3+1] <= w_ff[k*3+2];
            end
            w_ff[2] <= rd_o_ff;
            w_ff[5] <= rd_n_ff;
            w_ff[8] <= h_ff;
         end
         if (out_load) begin
            nx_ff <= cx_ff;
            ny_ff <= cy_ff;
            nz_ff <= cz_ff;
            lo_ff <= lastf_ff;
            rv_ff <= 1'b1;
         end else if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_CALC: begin
            ax_ff <= 28'(2 * w_ff[3] - 2 * w_ff[5] + w_ff[1] - w_ff[2] + w_ff[6] - w_ff[7]);
            az_ff <= 28'(2 * w_ff[1] - 2 * w_ff[7] + w_ff[2] - w_ff[5] + w_ff[3] - w_ff[6]);
            ay_ff <= {3'd0, step_ff} * 27'd6;
            sq_ff <= 2'd0;
            s_ff <= '0;
         end
         S_SQ: begin
            s_ff <= s_ff + sqr;
            sq_ff <= sq_ff + 2'd1;
            res_ff <= '0;
            bit_ff <= 64'd1 << 62;
         end
         S_SQRT: begin
            if (ge) begin
               s_ff <= dif;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else res_ff <= res_ff >> 1;
            bit_ff <= bit_ff >> 2;
            comp_ff <= 2'd0;
         end
         S_DINIT: begin
            // numerator 32768*|a| + len, divisor 2*len aligned to quotient bit 14
            s_ff <= {21'd0, mag, 15'd0} + res_ff;
            bit_ff <= {res_ff[48:0], 15'd0};
            quo_ff <= '0;
            dcnt_ff <= 4'd14;
         end
         S_DIV: begin
            if (ge) s_ff <= dif;
            quo_ff <= qn;
            bit_ff <= bit_ff >> 1;
            dcnt_ff <= dcnt_ff - 4'd1;
            if (dcnt_ff == 4'd0) begin
               case (comp_ff)
                  2'd0: cx_ff <= cval;
                  2'd1: cy_ff <= cval;
                  default: cz_ff <= cval;
               endcase
               comp_ff <= comp_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_normal_x = nx_ff;
   assign rsp_normal_y = ny_ff;
   assign rsp_normal_z = nz_ff;
   assign rsp_last = lo_ff;

   `ASSERT_CLK(no_accept_busy, clock, reset, (state_ff != S_IDLE) |-> !accept)
   `ASSERT_CLK(rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid)
   `ASSERT_CLK(rsp_steady_x, clock, reset, (rsp_valid && rsp_stall) |=> $stable(rsp_normal_x))
   `ASSERT_CLK(rsp_steady_last, clock, reset, (rsp_valid && rsp_stall) |=> $stable(rsp_last))
endmodule
`default_nettype wire
